[sv/headset_jack_detect_controller_core_defines.svh]
// ----------------------------------------------------------------------------
// headset jack detect controller core defines
// assertion macros shared by the rtl files of the block
// ----------------------------------------------------------------------------
`ifndef HEADSET_JACK_DETECT_CONTROLLER_CORE_DEFINES_SVH
`define HEADSET_JACK_DETECT_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define HJDC_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("hjdc invariant violated");
// antecedent implies property, out of reset
`define HJDC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hjdc implication violated");
// antecedent implies property on the next edge
`define HJDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hjdc next-cycle check violated");
`else
`define HJDC_ASSERT_ALWAYS(lbl, cond)
`define HJDC_ASSERT_IMPLY(lbl, ante, cons)
`define HJDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/hjdc_pkg.sv]
// ----------------------------------------------------------------------------
// hjdc_pkg
// shared types and constants of the headset jack detect controller
// ----------------------------------------------------------------------------
package hjdc_pkg;

	localparam int CFG_BITS      = 12;
	localparam int LIMIT_BITS    = 4;
	localparam int CFG_IDX_BITS  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_INSERT_SETTLE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_SETTLE = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOOK_SETTLE    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECHECK_DELAY  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECHECK_LIMIT  = 3'd4;

	// register reset values
	localparam logic [CFG_BITS-1:0]   INSERT_SETTLE_RST  = 12'd600;
	localparam logic [CFG_BITS-1:0]   CONFIRM_SETTLE_RST = 12'd300;
	localparam logic [CFG_BITS-1:0]   HOOK_SETTLE_RST    = 12'd65;
	localparam logic [CFG_BITS-1:0]   RECHECK_DELAY_RST  = 12'd100;
	localparam logic [LIMIT_BITS-1:0] RECHECK_RST        = 4'd10;

	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_HEADSET  = 2'd1,
		KIND_EARPHONE = 2'd2
	} kind_t;

	typedef struct packed {
		logic hook_level;
		logic jack_level;
	} item_t;

	typedef struct packed {
		logic [CFG_BITS-1:0]   insert_settle_ms;
		logic [CFG_BITS-1:0]   confirm_settle_ms;
		logic [CFG_BITS-1:0]   hook_settle_ms;
		logic [CFG_BITS-1:0]   recheck_delay_ms;
		logic [LIMIT_BITS-1:0] recheck_limit;
	} cfg_t;

	typedef struct packed {
		logic  type_report;
		logic  key_pressed;
		logic  mic_enable;
		kind_t device_type;
	} result_t;

endpackage

[sv/headset_jack_detect_controller_core.sv]
// ----------------------------------------------------------------------------
// headset_jack_detect_controller_core
// plug and hook detection for a headset jack, one pin sample per tick
// ----------------------------------------------------------------------------
// usage:
//   s_* stream: one request per millisecond tick, s_tdata[0] jack pin sample
//     (0 plugged), s_tdata[1] hook pin sample
//   m_* stream: one result per request, device type, mic bias, media key and
//     a type report flag that is high on the tick a jack sequence finishes
//   cfg_* port: settle times, recheck delay and recheck limit, written by
//     index; cfg_ready always high; user writes only while idle, not enforced
// throughput: one request per cycle while m_tready stays high; the detect
//   engine does a full tick of both timers and watchers per request
// path: a taken request passes the queue stage, then the engine output
//   register, before its result shows on m_tdata
// stall: a two-entry queue sits between the input side and the engine, so
//   the input keeps flowing while one result waits on m_tready; s_tready
//   drops only once the queue is full
// reset: arst_n clears all sequencing state at once, registers return to
//   600/300/65/100 ticks and a recheck limit of ten, no clearing pass
// ----------------------------------------------------------------------------
module headset_jack_detect_controller_core #(
	parameter int TIMER_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] jack_level, [1] hook_level, rest zero
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [1:0] device_type, [2] mic_enable,
	                               // [3] key_pressed, [4] type_report, rest zero
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [hjdc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [hjdc_pkg::CFG_BITS-1:0]     cfg_data
);
	import hjdc_pkg::*;

	cfg_t    cfg_q;
	item_t   s_item;
	item_t   q_head;
	logic    q_full;
	logic    q_not_empty;
	logic    q_pop;
	logic    push;
	result_t result;

	// front: accept a request whenever the queue has room
	assign s_tready          = !q_full;
	assign push              = s_tvalid && s_tready;
	assign s_item.jack_level = s_tdata[0];
	assign s_item.hook_level = s_tdata[1];

	// configuration registers, writes beyond the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.insert_settle_ms  <= INSERT_SETTLE_RST;
			cfg_q.confirm_settle_ms <= CONFIRM_SETTLE_RST;
			cfg_q.hook_settle_ms    <= HOOK_SETTLE_RST;
			cfg_q.recheck_delay_ms  <= RECHECK_DELAY_RST;
			cfg_q.recheck_limit     <= RECHECK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_INSERT_SETTLE:  cfg_q.insert_settle_ms  <= cfg_data;
				REG_CONFIRM_SETTLE: cfg_q.confirm_settle_ms <= cfg_data;
				REG_HOOK_SETTLE:    cfg_q.hook_settle_ms    <= cfg_data;
				REG_RECHECK_DELAY:  cfg_q.recheck_delay_ms  <= cfg_data;
				REG_RECHECK_LIMIT:  cfg_q.recheck_limit     <= cfg_data[LIMIT_BITS-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	// queue between the front and the engine
	hjdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (s_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (q_head)
	);

	// back: sequencing engine with its own output register
	hjdc_engine #(
		.TIMER_BITS (TIMER_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (q_not_empty),
		.in_item    (q_head),
		.in_pop     (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	// result packing, upper bits zero
	assign m_tdata = {3'b000, result.type_report, result.key_pressed,
		result.mic_enable, result.device_type};

endmodule

[sv/hjdc_queue.sv]
// ----------------------------------------------------------------------------
// hjdc_queue
// two-entry item queue between the accepting front and the detect engine
// ----------------------------------------------------------------------------
`include "headset_jack_detect_controller_core_defines.svh"

module hjdc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hjdc_pkg::item_t push_item,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output hjdc_pkg::item_t head_item
);
	import hjdc_pkg::*;

	localparam int DEPTH = 2;

	item_t      mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'(DEPTH));
	assign not_empty = (count_q != 2'd0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`HJDC_ASSERT_ALWAYS(a_count_bound, count_q <= 2'(DEPTH))
	`HJDC_ASSERT_IMPLY(a_pop_nonempty, pop, count_q != 2'd0)
	`HJDC_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 2'd1)

endmodule

[sv/hjdc_engine.sv]
// ----------------------------------------------------------------------------
// hjdc_engine
// detect engine: one tick of jack and hook sequencing per queued item
// ----------------------------------------------------------------------------
`include "headset_jack_detect_controller_core_defines.svh"

module hjdc_engine #(
	parameter int TIMER_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hjdc_pkg::cfg_t    cfg,
	input  logic              in_valid,
	input  hjdc_pkg::item_t   in_item,
	output logic              in_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output hjdc_pkg::result_t out_result
);
	import hjdc_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_INSERT  = 2'd1,
		PH_CONFIRM = 2'd2,
		PH_RECHECK = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [TIMER_BITS-1:0] jack_timer;
		logic [TIMER_BITS-1:0] hook_timer;
		logic                  hook_wait;
		kind_t                 kind;
		logic                  mic_on;
		logic                  key_held;
		logic [LIMIT_BITS-1:0] recheck_left;
		logic                  jack_armed;
		logic                  jack_trig;
		logic                  hook_armed;
		logic                  hook_trig;
		logic                  report;
	} st_t;

	st_t     st_q;
	st_t     st_nxt;
	logic    out_valid_q;
	result_t out_result_q;

	function automatic st_t f_end_seq(st_t s);
		st_t r;
		r = s;
		if (r.phase != PH_RECHECK) r.phase = PH_IDLE;
		r.jack_armed = 1'b1;
		r.report     = 1'b1;
		return r;
	endfunction

	function automatic st_t f_remove(st_t s, cfg_t c);
		st_t r;
		r = s;
		if (r.kind == KIND_HEADSET) begin
			r.mic_on     = 1'b0;
			r.key_held   = 1'b0;
			r.hook_armed = 1'b0;
		end
		r.kind         = KIND_NONE;
		r.jack_trig    = 1'b0;
		r.recheck_left = c.recheck_limit;
		return r;
	endfunction

	function automatic st_t f_start(st_t s, cfg_t c, logic jack);
		st_t r;
		r = s;
		r.jack_armed = 1'b0;
		if (!jack) begin
			r.mic_on     = 1'b1;
			r.phase      = PH_INSERT;
			r.jack_timer = TIMER_BITS'(c.insert_settle_ms);
		end else begin
			r.phase = PH_IDLE;
			r = f_remove(r, c);
			r = f_end_seq(r);
		end
		return r;
	endfunction

	assign in_pop = in_valid && (!out_valid_q || out_ready);

	// one tick: jack timer, jack watcher, hook timer, hook watcher
	always_comb begin
		st_t  s;
		logic jdone;
		logic hdone;
		logic jack;
		logic hook;
		s      = st_q;
		jack   = in_item.jack_level;
		hook   = in_item.hook_level;
		jdone  = 1'b0;
		hdone  = 1'b0;
		s.report = 1'b0;

		if (s.phase != PH_IDLE) begin
			if (s.jack_timer <= TIMER_BITS'(1)) begin
				s.jack_timer = '0;
				jdone        = 1'b1;
			end else begin
				s.jack_timer = s.jack_timer - TIMER_BITS'(1);
			end
		end

		if (jdone) begin
			if (s.phase == PH_RECHECK) begin
				s.phase = PH_IDLE;
				s = f_start(s, cfg, jack);
			end else if (jack) begin
				// abort: plug gone at a settle sample, mic left on
				s.phase = PH_IDLE;
				s = f_end_seq(s);
			end else if (s.phase == PH_INSERT) begin
				if (hook) begin
					s.kind   = KIND_EARPHONE;
					s.mic_on = 1'b0;
					s.phase  = PH_IDLE;
					if (s.recheck_left != '0) begin
						s.recheck_left = s.recheck_left - LIMIT_BITS'(1);
						s.phase        = PH_RECHECK;
						s.jack_timer   = TIMER_BITS'(cfg.recheck_delay_ms);
					end
					s.jack_trig = 1'b1;
					s = f_end_seq(s);
				end else begin
					s.phase      = PH_CONFIRM;
					s.jack_timer = TIMER_BITS'(cfg.confirm_settle_ms);
				end
			end else begin
				s.kind       = KIND_HEADSET;
				s.hook_trig  = 1'b1;
				s.hook_armed = 1'b1;
				s.jack_trig  = 1'b1;
				s.phase      = PH_IDLE;
				s = f_end_seq(s);
			end
		end

		if (s.jack_armed && (jack == s.jack_trig)) begin
			s = f_start(s, cfg, jack);
		end

		if (s.hook_wait) begin
			if (s.hook_timer <= TIMER_BITS'(1)) begin
				s.hook_timer = '0;
				hdone        = 1'b1;
			end else begin
				s.hook_timer = s.hook_timer - TIMER_BITS'(1);
			end
		end

		if (hdone) begin
			s.hook_wait = 1'b0;
			if (s.kind == KIND_HEADSET) begin
				if (hook) begin
					s.key_held  = 1'b1;
					s.hook_trig = 1'b0;
				end else if (s.key_held) begin
					s.key_held  = 1'b0;
					s.hook_trig = 1'b1;
				end
				s.hook_armed = 1'b1;
			end
		end

		if (s.hook_armed && (hook == s.hook_trig)) begin
			s.hook_armed = 1'b0;
			s.hook_wait  = 1'b1;
			s.hook_timer = TIMER_BITS'(cfg.hook_settle_ms);
		end

		st_nxt = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase        <= PH_IDLE;
			st_q.jack_timer   <= '0;
			st_q.hook_timer   <= '0;
			st_q.hook_wait    <= 1'b0;
			st_q.kind         <= KIND_NONE;
			st_q.mic_on       <= 1'b0;
			st_q.key_held     <= 1'b0;
			st_q.recheck_left <= RECHECK_RST;
			st_q.jack_armed   <= 1'b1;
			st_q.jack_trig    <= 1'b0;
			st_q.hook_armed   <= 1'b0;
			st_q.hook_trig    <= 1'b1;
			st_q.report       <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (in_pop) begin
				st_q        <= st_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			out_result_q.device_type <= st_nxt.kind;
			out_result_q.mic_enable  <= st_nxt.mic_on;
			out_result_q.key_pressed <= st_nxt.key_held;
			out_result_q.type_report <= st_nxt.report;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_result_q;

	`HJDC_ASSERT_IMPLY(a_key_needs_headset, st_q.key_held, st_q.kind == KIND_HEADSET)
	`HJDC_ASSERT_IMPLY(a_hook_arm_needs_headset, st_q.hook_armed, st_q.kind == KIND_HEADSET)
	`HJDC_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready, out_valid_q && $stable(out_result_q))

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the headset jack detect controller one tick at a time: every pin
// sample request is run through a local model of the plug and hook logic and
// each result is compared field by field, under random idling on both sides
// ----------------------------------------------------------------------------
module tb;
	import hjdc_pkg::*;

	localparam int CYCLE_LIMIT = 500_000;

	// no register behind this index, writes to it must change nothing
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

	typedef enum logic [1:0] {
		PHASE_IDLE,
		PHASE_INSERT,
		PHASE_CONFIRM,
		PHASE_RECHECK
	} seq_phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int ticks_sent = 0;

	result_t expected_states[$];

	// local copy of the registers and of the detection state
	cfg_t regs_shadow;
	seq_phase_t seq_phase;
	logic [CFG_BITS-1:0] seq_timer;
	logic [CFG_BITS-1:0] debounce_timer;
	logic debounce_busy;
	kind_t kind_now;
	logic mic_bias;
	logic key_down;
	logic [LIMIT_BITS-1:0] rechecks_left;
	logic jack_watch_armed;
	logic jack_watch_level;
	logic hook_watch_armed;
	logic hook_watch_level;
	logic seq_done;

	headset_jack_detect_controller_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [0] jack_level, [1] hook_level
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [1:0] device_type, [2] mic_enable, [3] key_pressed,
		                        // [4] type_report
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// detection model
	// ------------------------------------------------------------------------
	function automatic void finish_sequence();
		if (seq_phase != PHASE_RECHECK)
			seq_phase = PHASE_IDLE;
		jack_watch_armed = 1'b1;
		seq_done = 1'b1;
	endfunction

	// mic bias and key only belong to a headset
	function automatic void remove_device();
		if (kind_now == KIND_HEADSET) begin
			mic_bias = 1'b0;
			key_down = 1'b0;
			hook_watch_armed = 1'b0;
		end
		kind_now = KIND_NONE;
		jack_watch_level = 1'b0;
		rechecks_left = regs_shadow.recheck_limit;
	endfunction

	function automatic void start_sequence(logic jack);
		jack_watch_armed = 1'b0;
		if (jack == 1'b0) begin
			mic_bias = 1'b1;
			seq_phase = PHASE_INSERT;
			seq_timer = regs_shadow.insert_settle_ms;
		end else begin
			seq_phase = PHASE_IDLE;
			remove_device();
			finish_sequence();
		end
	endfunction

	function automatic result_t predict_jack_tick(logic jack, logic hook);
		result_t r;
		logic expired;
		seq_done = 1'b0;
		// jack timer first, a zero load ends like a one
		if (seq_phase != PHASE_IDLE) begin
			expired = (seq_timer <= 1);
			seq_timer = expired ? '0 : seq_timer - 1'b1;
			if (expired) begin
				if (seq_phase == PHASE_RECHECK) begin
					seq_phase = PHASE_IDLE;
					start_sequence(jack);
				end else if (jack == 1'b1) begin
					// plug gone at a settle sample, mic left as it is
					seq_phase = PHASE_IDLE;
					finish_sequence();
				end else if (seq_phase == PHASE_INSERT) begin
					if (hook == 1'b1) begin
						kind_now = KIND_EARPHONE;
						mic_bias = 1'b0;
						seq_phase = PHASE_IDLE;
						if (rechecks_left != 0) begin
							rechecks_left = rechecks_left - 1'b1;
							seq_phase = PHASE_RECHECK;
							seq_timer = regs_shadow.recheck_delay_ms;
						end
						jack_watch_level = 1'b1;
						finish_sequence();
					end else begin
						seq_phase = PHASE_CONFIRM;
						seq_timer = regs_shadow.confirm_settle_ms;
					end
				end else begin
					kind_now = KIND_HEADSET;
					hook_watch_level = 1'b1;
					hook_watch_armed = 1'b1;
					jack_watch_level = 1'b1;
					seq_phase = PHASE_IDLE;
					finish_sequence();
				end
			end
		end
		if (jack_watch_armed && jack == jack_watch_level)
			start_sequence(jack);
		// hook debounce, only a headset acts on the sample
		if (debounce_busy) begin
			expired = (debounce_timer <= 1);
			debounce_timer = expired ? '0 : debounce_timer - 1'b1;
			if (expired) begin
				debounce_busy = 1'b0;
				if (kind_now == KIND_HEADSET) begin
					if (hook == 1'b1) begin
						key_down = 1'b1;
						hook_watch_level = 1'b0;
					end else if (key_down) begin
						key_down = 1'b0;
						hook_watch_level = 1'b1;
					end
					hook_watch_armed = 1'b1;
				end
			end
		end
		if (hook_watch_armed && hook == hook_watch_level) begin
			hook_watch_armed = 1'b0;
			debounce_busy = 1'b1;
			debounce_timer = regs_shadow.hook_settle_ms;
		end
		r.device_type = kind_now;
		r.mic_enable = mic_bias;
		r.key_pressed = key_down;
		r.type_report = seq_done;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// result side: random stalls and the checker
	// ------------------------------------------------------------------------
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t ns", what, got, want, $time);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[4:0]);
			if (expected_states.size() == 0) begin
				report_mismatch("result with no request outstanding", int'(m_tdata), 0);
			end else begin
				want = expected_states.pop_front();
				if (got.device_type !== want.device_type)
					report_mismatch("device_type", int'(got.device_type),
						int'(want.device_type));
				if (got.mic_enable !== want.mic_enable)
					report_mismatch("mic_enable", int'(got.mic_enable),
						int'(want.mic_enable));
				if (got.key_pressed !== want.key_pressed)
					report_mismatch("key_pressed", int'(got.key_pressed),
						int'(want.key_pressed));
				if (got.type_report !== want.type_report)
					report_mismatch("type_report", int'(got.type_report),
						int'(want.type_report));
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------
	// valid is left high after a request, the next call lowers it if it idles
	task automatic send_tick(input logic jack, input logic hook);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, hook, jack};
		do @(posedge clk); while (!s_tready);
		expected_states.push_back(predict_jack_tick(jack, hook));
		ticks_sent++;
	endtask

	task automatic play_run(input logic jack, input logic hook, input int count);
		repeat (count) send_tick(jack, hook);
	endtask

	// sender holds off until every outstanding request has its result
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (expected_states.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_INSERT_SETTLE:  regs_shadow.insert_settle_ms = value;
			REG_CONFIRM_SETTLE: regs_shadow.confirm_settle_ms = value;
			REG_HOOK_SETTLE:    regs_shadow.hook_settle_ms = value;
			REG_RECHECK_DELAY:  regs_shadow.recheck_delay_ms = value;
			REG_RECHECK_LIMIT:  regs_shadow.recheck_limit = value[LIMIT_BITS-1:0];
			default: ;
		endcase
	endtask

	// only called with nothing outstanding, the spare index goes along each time
	task automatic set_timing(input int insert_ms, input int confirm_ms, input int hook_ms,
			input int delay_ms, input int limit);
		write_reg(REG_INSERT_SETTLE, CFG_BITS'(insert_ms));
		write_reg(REG_CONFIRM_SETTLE, CFG_BITS'(confirm_ms));
		write_reg(REG_HOOK_SETTLE, CFG_BITS'(hook_ms));
		write_reg(REG_RECHECK_DELAY, CFG_BITS'(delay_ms));
		write_reg(REG_RECHECK_LIMIT, CFG_BITS'(limit));
		write_reg(REG_SPARE, CFG_BITS'($urandom_range(4095)));
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// register reset values: earphone decision after the insert settle, then
	// a removal while the recheck waits
	task automatic test_reset_timing();
		play_run(1'b0, 1'b1, 603);
		play_run(1'b1, 1'b1, 2);
	endtask

	// one-tick settles, each special case in a few requests
	task automatic test_short_sequences();
		set_timing(1, 1, 1, 1, 1);
		play_run(1'b1, 1'b0, 2);   // empty jack, watcher waits for a low pin
		play_run(1'b0, 1'b0, 3);   // headset confirmed
		play_run(1'b0, 1'b1, 2);   // key press
		play_run(1'b0, 1'b0, 2);   // key release
		play_run(1'b0, 1'b1, 1);   // hook debounce running ...
		play_run(1'b1, 1'b1, 2);   // ... headset gone before the hook sample
		play_run(1'b0, 1'b1, 6);   // earphone, one recheck, then none left
		play_run(1'b1, 1'b0, 1);   // earphone removal, mic untouched
		play_run(1'b0, 1'b1, 2);   // earphone with a recheck pending ...
		play_run(1'b1, 1'b1, 1);   // ... dropped by the removal
		play_run(1'b0, 1'b0, 1);   // plug gone at the insert sample
		play_run(1'b1, 1'b0, 1);
		play_run(1'b0, 1'b0, 2);   // plug gone at the confirm sample
		play_run(1'b1, 1'b0, 1);
	endtask

	// mostly plug sessions with random content, some pin noise between them
	task automatic test_random_sessions(input int count);
		int target;
		int plug_len;
		int gap_len;
		bit earphone;
		logic hook_state;
		target = ticks_sent + count;
		while (ticks_sent < target) begin
			if ($urandom_range(9) < 7) begin
				plug_len = $urandom_range(1, 30);
				earphone = ($urandom_range(2) == 0);
				hook_state = 1'b0;
				repeat (plug_len) begin
					if (earphone)
						hook_state = ($urandom_range(9) != 0);
					else if ($urandom_range(5) == 0)
						hook_state = ~hook_state;
					send_tick(1'b0, hook_state);
				end
				gap_len = $urandom_range(1, 8);
				repeat (gap_len) send_tick(1'b1, 1'($urandom_range(1)));
			end else begin
				gap_len = $urandom_range(1, 6);
				repeat (gap_len) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		regs_shadow.insert_settle_ms = INSERT_SETTLE_RST;
		regs_shadow.confirm_settle_ms = CONFIRM_SETTLE_RST;
		regs_shadow.hook_settle_ms = HOOK_SETTLE_RST;
		regs_shadow.recheck_delay_ms = RECHECK_DELAY_RST;
		regs_shadow.recheck_limit = RECHECK_RST;
		seq_phase = PHASE_IDLE;
		seq_timer = '0;
		debounce_timer = '0;
		debounce_busy = 1'b0;
		kind_now = KIND_NONE;
		mic_bias = 1'b0;
		key_down = 1'b0;
		rechecks_left = RECHECK_RST;
		jack_watch_armed = 1'b1;
		jack_watch_level = 1'b0;
		hook_watch_armed = 1'b0;
		hook_watch_level = 1'b1;
		seq_done = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles often, receiver more often
		send_idle_pct = 26;
		recv_idle_pct = 55;
		test_reset_timing();
		wait_for_results();
		test_short_sequences();
		wait_for_results();

		// random phases: zero-length settles possible, recheck limit at both ends
		set_timing($urandom_range(8), $urandom_range(8), $urandom_range(8),
			$urandom_range(8), 0);
		send_idle_pct = 26;
		recv_idle_pct = 55;
		test_random_sessions(140);
		wait_for_results();

		set_timing($urandom_range(8), $urandom_range(8), $urandom_range(8),
			$urandom_range(8), 15);
		send_idle_pct = 55;
		recv_idle_pct = 26;
		test_random_sessions(140);
		wait_for_results();

		set_timing($urandom_range(8), $urandom_range(8), $urandom_range(8),
			$urandom_range(8), $urandom_range(15));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sessions(140);
		wait_for_results();

		repeat (4) @(posedge clk);
		if (expected_states.size() != 0)
			report_mismatch("results never delivered", expected_states.size(), 0);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
